@@ hdl/hrl_pkg.sv @@
`default_nettype none

package hrl_pkg;

  // record buffer size in bytes; only whole 32-bit words are kept
  localparam int RECORD_BYTES = 64;
  localparam int WORD_DEPTH   = RECORD_BYTES / 4;
  localparam int WADDR_W      = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
  localparam int WNX_W        = WADDR_W + 1;
  localparam int WCNT_W       = $clog2(WORD_DEPTH + 1);

  localparam logic [31:0] KEY_RESET = 32'h1234_5600;

  // configuration port
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_EXPECTED_KEY = '0;

  // record type codes as they appear on the wire
  localparam logic [7:0] TYPE_BYTE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_BYTE_UPPER = 8'h04;
  localparam logic [7:0] TYPE_BYTE_END   = 8'h05;
  localparam logic [7:0] TYPE_BYTE_KEY   = 8'h06;

  typedef enum logic [2:0] {
    REC_DATA    = 3'd0,
    REC_UPPER   = 3'd4,
    REC_KEY     = 3'd6,
    REC_UNKNOWN = 3'd7
  } rec_type_e;

  typedef enum logic [2:0] {
    ST_UPLOADING    = 3'd0,
    ST_SUCCESS      = 3'd1,
    ST_CSUM_FAIL    = 3'd2,
    ST_KEY_MISMATCH = 3'd3,
    ST_LEN_ERR      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_OFFH  = 3'd1,
    PH_OFFL  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE     = 2'd0,
    SEQ_WORD_RD  = 2'd1,
    SEQ_WORD_OUT = 2'd2,
    SEQ_STAT_OUT = 2'd3
  } seq_e;

  typedef struct packed {
    logic    take;        // byte accepted (skipped or parsed)
    logic    parse;       // byte accepted and parsed
    phase_e  phase;       // record field the byte belongs to
    status_e status;      // report to latch for this byte
    logic    key_set;     // key record verified
    logic    word_start;  // load word burst base and count
    logic    word_rd;     // read the current word from the buffer
    logic    word_next;   // advance to the next word
    logic    word_sel;    // output shows a word write
  } dp_cmd_t;

  typedef struct packed {
    logic      is_end;     // incoming byte is the end record type
    logic      count_zero;
    logic      count_over;
    logic      sum_zero;   // running sum plus byte is zero
    logic      key_match;
    logic      key_ok;
    rec_type_e rec_type;
    logic      data_done;  // this byte is the last data byte
    logic      has_words;
    logic      last_word;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/hrl_ram.sv @@
`default_nettype none

module hrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/hrl_datapath.sv @@
`default_nettype none

module hrl_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hrl_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  output logic [31:0]       expected_key_o,
  output hrl_pkg::dp_stat_t stat_o,
  output logic [2:0]        status_o,
  output logic [31:0]       write_address_o,
  output logic [31:0]       write_data_o
);

  logic [31:0]                  expected_key_q;
  logic [7:0]                   byte_index_q;
  logic [7:0]                   byte_count_q;
  hrl_pkg::rec_type_e           record_type_q;
  logic [15:0]                  offset_q;
  logic [15:0]                  upper_q;
  logic [7:0]                   sum_q;
  logic [31:0]                  key_acc_q;
  logic                         key_ok_q;
  logic [23:0]                  partial_q;
  logic [31:0]                  wbase_q;
  logic [hrl_pkg::WADDR_W-1:0]  wcnt_q;
  logic [hrl_pkg::WCNT_W-1:0]   nwords_q;
  logic [2:0]                   status_q;

  logic [7:0]                   sum_next;
  logic [31:0]                  key_sum;
  logic [8:0]                   index_next;
  logic                         store_en;
  logic [5:0]                   widx;
  logic [hrl_pkg::WNX_W-1:0]    wcnt_next;
  logic                         ram_we;
  logic [31:0]                  ram_rdata;

  assign sum_next   = sum_q + rx_byte_i;
  assign key_sum    = key_acc_q + {24'h00_0000, rx_byte_i};
  assign index_next = {1'b0, byte_index_q} + 9'd1;
  assign store_en   = {1'b0, byte_index_q} < 9'(hrl_pkg::RECORD_BYTES);
  assign widx       = byte_index_q[7:2];
  assign wcnt_next  = {1'b0, wcnt_q} + hrl_pkg::WNX_W'(1);

  always_comb begin
    stat_o.is_end     = (rx_byte_i == hrl_pkg::TYPE_BYTE_END);
    stat_o.count_zero = (byte_count_q == 8'h00);
    stat_o.count_over = ({1'b0, byte_count_q} > 9'(hrl_pkg::RECORD_BYTES));
    stat_o.sum_zero   = (sum_next == 8'h00);
    stat_o.key_match  = (key_acc_q == expected_key_q);
    stat_o.key_ok     = key_ok_q;
    stat_o.rec_type   = record_type_q;
    stat_o.data_done  = (index_next >= {1'b0, byte_count_q});
    stat_o.has_words  = (byte_count_q[7:2] != 6'd0);
    stat_o.last_word  = (wcnt_next == hrl_pkg::WNX_W'(nwords_q));
  end

  // a word goes to the buffer once its fourth byte arrives
  assign ram_we = cmd_i.parse && (cmd_i.phase == hrl_pkg::PH_DATA) && store_en &&
                  (byte_index_q[1:0] == 2'b11);

  hrl_ram #(
    .WIDTH (32),
    .DEPTH (hrl_pkg::WORD_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx[hrl_pkg::WADDR_W-1:0]),
    .wdata_i ({rx_byte_i, partial_q}),
    .re_i    (cmd_i.word_rd),
    .raddr_i (wcnt_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_key_q <= hrl_pkg::KEY_RESET;
      byte_index_q   <= 8'h00;
      byte_count_q   <= 8'h00;
      record_type_q  <= hrl_pkg::REC_UNKNOWN;
      offset_q       <= 16'h0000;
      upper_q        <= 16'h0000;
      sum_q          <= 8'h00;
      key_acc_q      <= 32'h0000_0000;
      key_ok_q       <= 1'b0;
      wcnt_q         <= '0;
      nwords_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        expected_key_q <= cfg_wdata_i;
      end
      if (cmd_i.parse) begin
        unique case (cmd_i.phase)
          hrl_pkg::PH_COUNT: begin
            byte_count_q <= rx_byte_i;
            sum_q        <= rx_byte_i;
            byte_index_q <= 8'h00;
          end
          hrl_pkg::PH_OFFH: begin
            sum_q    <= sum_next;
            offset_q <= {rx_byte_i, 8'h00};
          end
          hrl_pkg::PH_OFFL: begin
            sum_q         <= sum_next;
            offset_q[7:0] <= rx_byte_i;
          end
          hrl_pkg::PH_TYPE: begin
            if (stat_o.is_end) begin
              // end record clears the whole upload context
              byte_index_q  <= 8'h00;
              byte_count_q  <= 8'h00;
              record_type_q <= hrl_pkg::REC_UNKNOWN;
              offset_q      <= 16'h0000;
              sum_q         <= 8'h00;
              upper_q       <= 16'h0000;
              key_acc_q     <= 32'h0000_0000;
              key_ok_q      <= 1'b0;
            end else begin
              sum_q <= sum_next;
              priority if (rx_byte_i == hrl_pkg::TYPE_BYTE_DATA) begin
                record_type_q <= hrl_pkg::REC_DATA;
              end else if (rx_byte_i == hrl_pkg::TYPE_BYTE_UPPER) begin
                record_type_q <= hrl_pkg::REC_UPPER;
                upper_q       <= 16'h0000;
              end else if (rx_byte_i == hrl_pkg::TYPE_BYTE_KEY) begin
                record_type_q <= hrl_pkg::REC_KEY;
                key_acc_q     <= 32'h0000_0000;
              end else begin
                record_type_q <= hrl_pkg::REC_UNKNOWN;
              end
            end
          end
          hrl_pkg::PH_DATA: begin
            sum_q        <= sum_next;
            byte_index_q <= index_next[7:0];
            if (record_type_q == hrl_pkg::REC_UPPER) begin
              upper_q <= {upper_q[7:0], rx_byte_i};
            end else if (record_type_q == hrl_pkg::REC_KEY) begin
              key_acc_q <= {key_sum[23:0], 8'h00};
            end
          end
          hrl_pkg::PH_SUM: begin
            byte_index_q  <= 8'h00;
            byte_count_q  <= 8'h00;
            record_type_q <= hrl_pkg::REC_UNKNOWN;
            offset_q      <= 16'h0000;
            sum_q         <= 8'h00;
            if (cmd_i.key_set) begin
              key_ok_q <= 1'b1;
            end
          end
          default: begin
            sum_q <= sum_q;
          end
        endcase
      end
      if (cmd_i.word_start) begin
        nwords_q <= hrl_pkg::WCNT_W'(byte_count_q[7:2]);
        wcnt_q   <= '0;
      end else if (cmd_i.word_next) begin
        wcnt_q <= wcnt_next[hrl_pkg::WADDR_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.parse && (cmd_i.phase == hrl_pkg::PH_DATA)) begin
      partial_q <= {rx_byte_i, partial_q[23:8]};
    end
    if (cmd_i.word_start) begin
      wbase_q <= {upper_q, offset_q};
    end else if (cmd_i.word_next) begin
      wbase_q <= wbase_q + 32'd4;
    end
    if (cmd_i.take) begin
      status_q <= cmd_i.status;
    end
  end

  assign expected_key_o  = expected_key_q;
  assign status_o        = cmd_i.word_sel ? hrl_pkg::ST_UPLOADING : status_q;
  assign write_address_o = cmd_i.word_sel ? wbase_q : 32'h0000_0000;
  assign write_data_o    = cmd_i.word_sel ? ram_rdata : 32'h0000_0000;

endmodule

`default_nettype wire

@@ hdl/hrl_ctrl.sv @@
`default_nettype none

module hrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hrl_pkg::dp_stat_t stat_i,
  output hrl_pkg::dp_cmd_t  cmd_o
);

  hrl_pkg::seq_e   seq_q, seq_d;
  hrl_pkg::phase_e phase_q, phase_d;
  logic [1:0]      skip_q, skip_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= hrl_pkg::SEQ_IDLE;
      phase_q <= hrl_pkg::PH_COUNT;
      skip_q  <= 2'd2;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      skip_q  <= skip_d;
    end
  end

  assign in_ready_o = (seq_q == hrl_pkg::SEQ_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    seq_d       = seq_q;
    phase_d     = phase_q;
    skip_d      = skip_q;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.phase = phase_q;

    unique case (seq_q)
      hrl_pkg::SEQ_IDLE: begin
        if (accept) begin
          cmd_o.take = 1'b1;
          seq_d      = hrl_pkg::SEQ_STAT_OUT;
          if (skip_q != 2'd0) begin
            skip_d       = skip_q - 2'd1;
            cmd_o.status = hrl_pkg::ST_UPLOADING;
          end else begin
            cmd_o.parse = 1'b1;
            unique case (phase_q)
              hrl_pkg::PH_COUNT: phase_d = hrl_pkg::PH_OFFH;
              hrl_pkg::PH_OFFH:  phase_d = hrl_pkg::PH_OFFL;
              hrl_pkg::PH_OFFL:  phase_d = hrl_pkg::PH_TYPE;
              hrl_pkg::PH_TYPE: begin
                if (stat_i.is_end) begin
                  phase_d      = hrl_pkg::PH_COUNT;
                  skip_d       = 2'd2;
                  cmd_o.status = hrl_pkg::ST_SUCCESS;
                end else if (stat_i.count_zero) begin
                  phase_d = hrl_pkg::PH_SUM;
                end else begin
                  phase_d = hrl_pkg::PH_DATA;
                end
              end
              hrl_pkg::PH_DATA: begin
                if (stat_i.data_done) begin
                  phase_d = hrl_pkg::PH_SUM;
                end
              end
              hrl_pkg::PH_SUM: begin
                phase_d = hrl_pkg::PH_COUNT;
                skip_d  = 2'd1;
                priority if (stat_i.count_over) begin
                  cmd_o.status = hrl_pkg::ST_LEN_ERR;
                end else if (!stat_i.sum_zero) begin
                  cmd_o.status = hrl_pkg::ST_CSUM_FAIL;
                end else if (stat_i.rec_type == hrl_pkg::REC_KEY) begin
                  if (stat_i.key_match) begin
                    cmd_o.key_set = 1'b1;
                    cmd_o.status  = hrl_pkg::ST_SUCCESS;
                  end else begin
                    cmd_o.status = hrl_pkg::ST_KEY_MISMATCH;
                  end
                end else if (stat_i.rec_type == hrl_pkg::REC_DATA) begin
                  cmd_o.status = hrl_pkg::ST_SUCCESS;
                  if (stat_i.key_ok && stat_i.has_words) begin
                    cmd_o.word_start = 1'b1;
                    seq_d            = hrl_pkg::SEQ_WORD_RD;
                  end
                end else if (stat_i.rec_type == hrl_pkg::REC_UPPER) begin
                  cmd_o.status = hrl_pkg::ST_SUCCESS;
                end else begin
                  cmd_o.status = hrl_pkg::ST_UPLOADING;
                end
              end
              default: phase_d = hrl_pkg::PH_COUNT;
            endcase
          end
        end
      end
      hrl_pkg::SEQ_WORD_RD: begin
        cmd_o.word_rd = 1'b1;
        seq_d         = hrl_pkg::SEQ_WORD_OUT;
      end
      hrl_pkg::SEQ_WORD_OUT: begin
        out_valid_o    = 1'b1;
        cmd_o.word_sel = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last_word) begin
            seq_d = hrl_pkg::SEQ_STAT_OUT;
          end else begin
            cmd_o.word_next = 1'b1;
            seq_d           = hrl_pkg::SEQ_WORD_RD;
          end
        end
      end
      hrl_pkg::SEQ_STAT_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          seq_d = hrl_pkg::SEQ_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/hex_record_loader_core.sv @@
`default_nettype none

// channel     dir  handshake                      payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tdata: rx_byte
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata, tuser: kind, tlast: last
// apb config  in   psel & penable, pready = 1     expected_key at byte address 0
//
// a byte that yields only a status report is accepted, then the report goes out
// a checksum byte of a keyed data record with n words is accepted, then each word
//   is read from the word buffer ram and output, then the status report goes out
// one transaction at a time through the output registers; stalls on m_axis
//   hold the output and keep s_axis_tready low
// rst_ni is asynchronous, active low; the word buffer needs no clearing pass,
//   words are only read back from the record that wrote them

module hex_record_loader_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte stream in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  // result stream out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [2:0] status, [34:3] write_address, [66:35] write_data, [71:67] zero
  output logic [71:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,   // [0] kind
  output logic                        m_axis_tlast,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hrl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  hrl_pkg::dp_cmd_t  cmd;
  hrl_pkg::dp_stat_t stat;
  logic              cfg_hit;
  logic              cfg_we;
  logic [31:0]       expected_key;
  logic [2:0]        status;
  logic [31:0]       write_address;
  logic [31:0]       write_data;

  // apb decode, register index from the word address
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[hrl_pkg::PADDR_W-1:2] == hrl_pkg::REG_EXPECTED_KEY);
  assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? expected_key : 32'h0000_0000;

  // record parser and output sequencing
  hrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // record fields, checksum, key, upper address and the word buffer
  hrl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rx_byte_i       (s_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (pwdata),
    .expected_key_o  (expected_key),
    .stat_o          (stat),
    .status_o        (status),
    .write_address_o (write_address),
    .write_data_o    (write_data)
  );

  // word writes carry kind 1 and are never last; the status report closes the byte
  assign m_axis_tuser = cmd.word_sel;
  assign m_axis_tlast = !cmd.word_sel;
  assign m_axis_tdata = {5'b00000, write_data, write_address, status};

endmodule

`default_nettype wire

@@ hdl/hrl_checker.sv @@
`default_nettype none

module hrl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // input is only taken while no result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // an accepted byte closes the input until its results are out
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again before the results");

  // word writes are never last, status reports always are
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == !m_axis_tuser))
    else $error("tlast does not match result kind");

  // word writes carry no status code
  a_word_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2:0] == hrl_pkg::ST_UPLOADING))
    else $error("status set on a word write");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind hex_record_loader_core hrl_checker u_hrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // one byte of the record stream moves per input transaction, one report or
  // one word write per output transaction
  typedef struct packed {
    logic             kind;
    hrl_pkg::status_e status;
    logic [31:0]      addr;
    logic [31:0]      data;
    logic             last;
  } result_t;

  // receiver stall patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_PERIODIC
  } ready_mode_e;

  localparam logic [hrl_pkg::PADDR_W-1:0] KEY_ADDR = {hrl_pkg::REG_EXPECTED_KEY, 2'b00};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;           // [2:0] status, [34:3] address, [66:35] data
  logic        m_axis_tuser;           // [0] kind
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [hrl_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata        = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  hex_record_loader_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser shadow state
  // ---------------------------------------------------------------------------
  logic [31:0]        key_cfg;
  hrl_pkg::phase_e    prs_phase;
  int                 skip_cnt;
  int                 data_pos;
  logic [7:0]         rec_len;
  hrl_pkg::rec_type_e rec_kind;
  logic [15:0]        rec_offs;
  logic [15:0]        hi_addr;
  logic [7:0]         csum_acc;
  logic [31:0]        key_fold;
  logic               keyed;
  logic [7:0]         rec_buf [hrl_pkg::RECORD_BYTES];

  result_t     pending_results [$];  // results still owed by the block
  logic [7:0]  payload [$];          // data bytes of the record being built
  int          errors     = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("tb: mismatch %0d: %s", errors, msg);
  endtask

  task automatic owe_result(input logic kind, input hrl_pkg::status_e st,
                            input logic [31:0] addr, input logic [31:0] data);
    result_t r;
    r.kind   = kind;
    r.status = st;
    r.addr   = addr;
    r.data   = data;
    r.last   = !kind;  // the status report always closes the byte
    pending_results.push_back(r);
  endtask

  task automatic close_record(input int skip);
    prs_phase = hrl_pkg::PH_COUNT;
    skip_cnt  = skip;
    data_pos  = 0;
    rec_len   = 8'h00;
    rec_kind  = hrl_pkg::REC_UNKNOWN;
    rec_offs  = 16'h0000;
    csum_acc  = 8'h00;
  endtask

  task automatic parser_reset();
    key_cfg = hrl_pkg::KEY_RESET;
    close_record(2);
    hi_addr  = 16'h0000;
    key_fold = 32'h0;
    keyed    = 1'b0;
  endtask

  // advance the shadow parser by one accepted byte and queue what it owes
  task automatic parse_byte(input logic [7:0] b);
    hrl_pkg::status_e st;
    logic [7:0]       total;
    logic [31:0]      waddr;
    st = hrl_pkg::ST_UPLOADING;
    if (skip_cnt > 0) begin
      skip_cnt--;
    end else begin
      case (prs_phase)
        hrl_pkg::PH_COUNT: begin
          rec_len   = b;
          csum_acc  = b;
          data_pos  = 0;
          prs_phase = hrl_pkg::PH_OFFH;
        end
        hrl_pkg::PH_OFFH: begin
          csum_acc  = csum_acc + b;
          rec_offs  = {b, 8'h00};
          prs_phase = hrl_pkg::PH_OFFL;
        end
        hrl_pkg::PH_OFFL: begin
          csum_acc      = csum_acc + b;
          rec_offs[7:0] = b;
          prs_phase     = hrl_pkg::PH_TYPE;
        end
        hrl_pkg::PH_TYPE: begin
          if (b == hrl_pkg::TYPE_BYTE_END) begin
            // end record: report at once, drop key and upper address
            close_record(2);
            hi_addr  = 16'h0000;
            key_fold = 32'h0;
            keyed    = 1'b0;
            st       = hrl_pkg::ST_SUCCESS;
          end else begin
            csum_acc = csum_acc + b;
            if (b == hrl_pkg::TYPE_BYTE_DATA) begin
              rec_kind = hrl_pkg::REC_DATA;
            end else if (b == hrl_pkg::TYPE_BYTE_UPPER) begin
              rec_kind = hrl_pkg::REC_UPPER;
              hi_addr  = 16'h0000;
            end else if (b == hrl_pkg::TYPE_BYTE_KEY) begin
              rec_kind = hrl_pkg::REC_KEY;
              key_fold = 32'h0;
            end else begin
              rec_kind = hrl_pkg::REC_UNKNOWN;
            end
            // zero count goes straight to the checksum
            prs_phase = (rec_len == 8'h00) ? hrl_pkg::PH_SUM : hrl_pkg::PH_DATA;
          end
        end
        hrl_pkg::PH_DATA: begin
          csum_acc = csum_acc + b;
          if (data_pos < hrl_pkg::RECORD_BYTES) rec_buf[data_pos] = b;
          if (rec_kind == hrl_pkg::REC_UPPER) begin
            hi_addr = {hi_addr[7:0], b};
          end else if (rec_kind == hrl_pkg::REC_KEY) begin
            key_fold = (key_fold + b) << 8;
          end
          data_pos++;
          if (data_pos >= rec_len) prs_phase = hrl_pkg::PH_SUM;
        end
        default: begin
          total = csum_acc + b;
          if (rec_len > hrl_pkg::RECORD_BYTES) begin
            st = hrl_pkg::ST_LEN_ERR;
          end else if (total != 8'h00) begin
            st = hrl_pkg::ST_CSUM_FAIL;
          end else if (rec_kind == hrl_pkg::REC_KEY) begin
            if (key_fold == key_cfg) begin
              keyed = 1'b1;
              st    = hrl_pkg::ST_SUCCESS;
            end else begin
              st = hrl_pkg::ST_KEY_MISMATCH;
            end
          end else if (rec_kind == hrl_pkg::REC_DATA) begin
            if (keyed) begin
              waddr = {hi_addr, rec_offs};
              // whole words only, trailing bytes are dropped
              for (int w = 0; w < rec_len / 4; w++) begin
                owe_result(1'b1, hrl_pkg::ST_UPLOADING, waddr,
                           {rec_buf[4*w+3], rec_buf[4*w+2], rec_buf[4*w+1], rec_buf[4*w]});
                waddr = waddr + 32'd4;
              end
            end
            st = hrl_pkg::ST_SUCCESS;
          end else if (rec_kind == hrl_pkg::REC_UPPER) begin
            st = hrl_pkg::ST_SUCCESS;
          end
          close_record(1);
        end
      endcase
    end
    owe_result(1'b0, st, 32'h0, 32'h0);
  endtask

  // ---------------------------------------------------------------------------
  // byte sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    parse_byte(b);
  endtask

  // bytes the parser throws away after a record or an end record
  task automatic send_skipped();
    while (skip_cnt > 0) send_byte(8'($urandom));
  endtask

  // count, offset, type, payload, checksum (an end record stops after the type); the count is the payload size
  task automatic send_record(input logic [15:0] offs, input logic [7:0] typ,
                             input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] len;
    len = 8'(payload.size());
    sum = len + offs[15:8] + offs[7:0] + typ;
    send_byte(len);
    send_byte(offs[15:8]);
    send_byte(offs[7:0]);
    send_byte(typ);
    if (typ != hrl_pkg::TYPE_BYTE_END) begin
      foreach (payload[i]) begin
        sum = sum + payload[i];
        send_byte(payload[i]);
      end
      sum = -sum;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum);
    end
    send_skipped();
  endtask

  task automatic fill_random(input int n);
    payload.delete();
    repeat (n) payload.push_back(8'($urandom));
  endtask

  // key bytes: earlier bytes fold out, the last three land in bits 31:8
  task automatic fill_key(input logic [31:0] k, input bit good);
    fill_random($urandom_range(0, 2));
    payload.push_back(k[31:24]);
    payload.push_back(k[23:16]);
    payload.push_back(k[15:8]);
    if (!good) payload[payload.size()-1] ^= 8'h01 << $urandom_range(0, 7);
  endtask

  // wait until every owed result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    key_cfg = value;
    // return the bus to idle before the next bus access
    @(posedge clk_i);
  endtask

  task automatic apb_check_key();
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= KEY_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== key_cfg)
      flag_error($sformatf("expected_key read %h, want %h", got, key_cfg));
  endtask

  // ---------------------------------------------------------------------------
  // result checker and receiver stall pattern
  // ---------------------------------------------------------------------------
  int          ready_cycle = 0;
  ready_mode_e ready_mode  = RDY_ALWAYS;

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind   = m_axis_tuser;
      got.status = hrl_pkg::status_e'(m_axis_tdata[2:0]);
      got.addr   = m_axis_tdata[34:3];
      got.data   = m_axis_tdata[66:35];
      got.last   = m_axis_tlast;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d status %0d addr %h data %h",
                             got.kind, got.status, got.addr, got.data));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_error($sformatf(
            "kind %0d/%0d status %0d/%0d addr %h/%h data %h/%h last %0d/%0d (want/got)",
            want.kind, got.kind, want.status, got.status, want.addr, got.addr,
            want.data, got.data, want.last, got.last));
      end
    end
    // stall pattern is redrawn at random, then tready is driven by it
    ready_cycle++;
    if (ready_cycle % 48 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS:  m_axis_tready <= 1'b1;
      RDY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY:  m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:     m_axis_tready <= ((ready_cycle % 7) < 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value of the key register and the two bytes skipped after reset
  task automatic test_reset_and_skip();
    apb_check_key();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // keyed data records: word packing, trailing bytes, zero count, full buffer
  task automatic test_keyed_writes();
    fill_key(key_cfg, 1'b1);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_KEY, 1'b0);
    fill_random(8);
    send_record(16'h1000, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_random(6);
    send_record(16'hFFFF, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_random(0);
    send_record(16'h0040, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_random(3);
    send_record(16'h0100, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_random(hrl_pkg::RECORD_BYTES);
    send_record(16'hFFC0, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
  endtask

  // upper address folding, clearing at record start, address wrap
  task automatic test_upper_address();
    payload.delete();
    payload.push_back(8'hFF);
    payload.push_back(8'hFF);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_UPPER, 1'b0);
    fill_random(8);
    send_record(16'hFFFC, hrl_pkg::TYPE_BYTE_DATA, 1'b0);   // wraps past the top
    payload.delete();
    payload.push_back(8'h12);
    payload.push_back(8'hAB);
    payload.push_back(8'hCD);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_UPPER, 1'b0);
    fill_random(4);
    send_record(16'h0010, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_random(0);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_UPPER, 1'b0);  // zero count leaves upper cleared
    fill_random(4);
    send_record(16'h0020, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
  endtask

  // checksum fail, unknown types, over-long records, key mismatch
  task automatic test_error_status();
    fill_random(8);
    send_record(16'h2000, hrl_pkg::TYPE_BYTE_DATA, 1'b1);
    fill_random(2);
    send_record(16'h0000, 8'h01, 1'b0);
    fill_random(5);
    send_record(16'h0000, 8'hFF, 1'b1);
    fill_random(0);
    send_record(16'h0000, 8'h07, 1'b0);
    fill_random(hrl_pkg::RECORD_BYTES + 1);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_random(255);
    send_record(16'hFFFF, hrl_pkg::TYPE_BYTE_KEY, 1'b1);
    fill_key(key_cfg, 1'b0);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_KEY, 1'b0);
    fill_random(4);
    send_record(16'h3000, hrl_pkg::TYPE_BYTE_DATA, 1'b0);  // key still held after mismatch
  endtask

  // end record clears the key; data afterwards is not written
  task automatic test_end_record();
    fill_random(0);
    send_record(16'($urandom), hrl_pkg::TYPE_BYTE_END, 1'b0);
    fill_random(8);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    fill_key(key_cfg, 1'b1);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_KEY, 1'b1);   // bad checksum does not key
    fill_random(4);
    send_record(16'h0004, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
  endtask

  // key register extremes, each checked by a key record
  task automatic test_key_register();
    drain();
    apb_write(32'h0000_0000);
    apb_check_key();
    fill_random(0);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_KEY, 1'b0);   // empty key record folds to zero
    fill_random(4);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_DATA, 1'b0);
    drain();
    apb_write(32'hFFFF_FFFF);
    apb_check_key();
    fill_key(key_cfg, 1'b1);                               // low byte set, cannot match
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_KEY, 1'b0);
    drain();
    apb_write({24'($urandom), 8'h00});
    apb_check_key();
    fill_key(key_cfg, 1'b1);
    send_record(16'h0000, hrl_pkg::TYPE_BYTE_KEY, 1'b0);
  endtask

  task automatic random_record();
    int         pick;
    int         n;
    logic [7:0] typ;
    bit         bad;
    pick = $urandom_range(0, 99);
    bad  = ($urandom_range(0, 9) == 0);
    if (pick < 45) begin
      n = $urandom_range(0, 9);
      if (n < 7) n = $urandom_range(0, 16);
      else if (n < 9) n = $urandom_range(17, hrl_pkg::RECORD_BYTES);
      else n = hrl_pkg::RECORD_BYTES;
      fill_random(n);
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_DATA, bad);
    end else if (pick < 62) begin
      fill_key(key_cfg, $urandom_range(0, 9) < 7);
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_KEY, bad);
    end else if (pick < 72) begin
      fill_random($urandom_range(0, 4));
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_UPPER, bad);
    end else if (pick < 77) begin
      fill_random(0);
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_END, 1'b0);
    end else if (pick < 85) begin
      do typ = 8'($urandom);
      while (typ == hrl_pkg::TYPE_BYTE_DATA || typ == hrl_pkg::TYPE_BYTE_UPPER ||
             typ == hrl_pkg::TYPE_BYTE_END || typ == hrl_pkg::TYPE_BYTE_KEY);
      fill_random($urandom_range(0, 8));
      send_record(16'($urandom), typ, bad);
    end else if (pick < 88) begin
      n = ($urandom_range(0, 3) == 0)
          ? $urandom_range(hrl_pkg::RECORD_BYTES + 1, 255)
          : $urandom_range(hrl_pkg::RECORD_BYTES + 1, hrl_pkg::RECORD_BYTES + 16);
      fill_random(n);
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_DATA, bad);
    end else if (pick < 91) begin
      // line noise, then keep feeding until the parser is back at a count byte
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      while (prs_phase != hrl_pkg::PH_COUNT || skip_cnt != 0) send_byte(8'($urandom));
    end else begin
      // data record with a short key record in front to keep writes flowing
      fill_key(key_cfg, 1'b1);
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_KEY, 1'b0);
      fill_random($urandom_range(4, 20));
      send_record(16'($urandom), hrl_pkg::TYPE_BYTE_DATA, bad);
    end
  endtask

  // random stream in three phases, key register changed between them
  task automatic test_random_stream(input int total);
    int start;
    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0:       apb_write({24'($urandom), 8'h00});
        1:       apb_write(32'($urandom));
        default: apb_write(hrl_pkg::KEY_RESET);
      endcase
      start = bytes_sent;
      while (bytes_sent - start < total / 3) random_record();
    end
  endtask

  initial begin
    parser_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_skip();
    test_keyed_writes();
    test_upper_address();
    test_error_status();
    test_end_record();
    test_key_register();
    test_random_stream(96);

    drain();
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule
